### sv/spcprof_pkg.sv
`default_nettype none
package spcprof_pkg;

  // Table geometry and report length.
  localparam int TABLE_DEPTH  = 4096;
  localparam int PROBE_LIMIT  = 8;
  localparam int REPORT_COUNT = 25;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int PRB_W  = $clog2(PROBE_LIMIT + 1);
  localparam int RK_W   = $clog2(REPORT_COUNT + 1);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [31:0] HASH_MUL    = 32'd2654435761;
  localparam logic [31:0] SAT32       = 32'hFFFF_FFFF;
  localparam logic [15:0] MASK_RESET  = 16'd1023;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE      = 1'b0,
    CFG_SAMPLE_MASK = 1'b1
  } cfg_index_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE_RD,
    S_PROBE_CHK,
    S_SCAN,
    S_SCAN_TAIL,
    S_DECIDE,
    S_TAKE,
    S_TAKE_WAIT,
    S_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr;        // zero one hit entry of the clearing pass
    logic tick;       // dispatch item accepted while enabled
    logic hash;       // load the first probe slot from the hash
    logic probe_chk;  // judge the probed slot, update or step
    logic rep_init;   // start a report
    logic scan_init;  // start a search for the hottest entry
    logic scan_rd;    // read the next hit entry of the search
    logic mark_last;  // flag the held result as the final one
    logic take_rd;    // read the winner's pc and zero its count
    logic take_load;  // load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic en;
    logic kind_rep;
    logic sample;
    logic total_zero;
    logic sweep_end;
    logic probe_match;
    logic probe_last;
    logic best_zero;
    logic pend;
    logic rep_full;
    logic out_last;
  } sts_t;

endpackage
`default_nettype wire

### sv/sampled_pc_hot_spot_profiler.sv
`default_nettype none
// Sampled program-counter hot-spot profiler.
//
// Input channel (in_valid/in_ready): kind 0 is a dispatch item carrying pc,
// kind 1 is a report request. Output channel (out_valid/out_ready): one item
// per reported table entry, hottest first, with last set on the final one.
// Configuration (cfg_we/cfg_index/cfg_data) sets enable and sample_mask; the
// user is to write it only while the block is idle, as the block does not
// enforce this. After reset the hit table is swept to zero, one entry per
// cycle; in_ready stays low until the sweep is done. A dispatch item that is
// not a sample, or any item while disabled, is accepted in idle and leaves
// the block idle. A sampled dispatch, once accepted, passes through S_HASH
// and one S_PROBE_RD, S_PROBE_CHK pair per probe (at most PROBE_LIMIT), as
// the table memories have a registered read. A report searches the whole hit
// table once per reported entry and waits for the receiver to accept each
// result. The first result is held back until the search for the next one
// shows whether it is the last. While the receiver stalls, the result is
// held and the next search waits; no new input item is accepted until the
// report ends.
module sampled_pc_hot_spot_profiler (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [spcprof_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [spcprof_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                kind,
  input  wire logic [31:0]                         pc,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic      [4:0]                          rank,
  output logic      [31:0]                         hot_pc,
  output logic      [31:0]                         hit_count,
  output logic      [31:0]                         sample_total,
  output logic                                     last
);

  // Commands go from the sequencer to the datapath; status comes back.
  spcprof_pkg::cmd_t cmd;
  spcprof_pkg::sts_t st;

  spcprof_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .kind         (kind),
    .pc           (pc),
    .cmd          (cmd),
    .st           (st),
    .rank         (rank),
    .hot_pc       (hot_pc),
    .hit_count    (hit_count),
    .sample_total (sample_total),
    .last         (last)
  );

  spcprof_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  // Every reported count is non-zero and can never exceed the sample total.
  a_out_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hit_count != 32'd0) && (hit_count <= sample_total))
    else $error("reported count out of range");

endmodule
`default_nettype wire

### sv/spcprof_ram.sv
`default_nettype none
module spcprof_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### sv/spcprof_dp.sv
`default_nettype none
module spcprof_dp (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [spcprof_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [spcprof_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                                kind,
  input  wire logic [31:0]                         pc,
  input  wire spcprof_pkg::cmd_t                   cmd,
  output spcprof_pkg::sts_t                        st,
  output logic      [4:0]                          rank,
  output logic      [31:0]                         hot_pc,
  output logic      [31:0]                         hit_count,
  output logic      [31:0]                         sample_total,
  output logic                                     last
);

  localparam int AW = spcprof_pkg::ADDR_W;
  localparam int PW = spcprof_pkg::PRB_W;
  localparam int KW = spcprof_pkg::RK_W;

  logic          en;
  logic [15:0]   mask;
  logic [15:0]   tick;
  logic [15:0]   tick_next;
  logic [31:0]   total;
  logic [31:0]   pc_reg;
  logic [31:0]   prod;
  logic [AW-1:0] slot;
  logic [PW-1:0] probe_i;
  logic [AW-1:0] sweep;
  logic          rd_vld;
  logic [AW-1:0] rd_idx;
  logic [31:0]   best_cnt;
  logic [AW-1:0] best_idx;
  logic [KW-1:0] k;

  logic          hit_we;
  logic [AW-1:0] hit_waddr;
  logic [31:0]   hit_wdata;
  logic [AW-1:0] hit_raddr;
  logic [31:0]   hit_rd;
  logic          pc_we;
  logic [AW-1:0] pc_raddr;
  logic [31:0]   pc_rd;
  logic [31:0]   hit_inc;
  logic          match;

  assign tick_next = tick + 16'd1;
  assign prod      = {2'b00, pc_reg[31:2]} * spcprof_pkg::HASH_MUL;
  assign hit_inc   = (hit_rd == spcprof_pkg::SAT32) ? hit_rd : hit_rd + 32'd1;
  // A zero count marks a free slot; its stale pc is never looked at.
  assign match     = (hit_rd == 32'd0) || (pc_rd == pc_reg);

  always_comb begin
    st.en          = en;
    st.kind_rep    = kind;
    st.sample      = (tick_next & mask) == 16'd0;
    st.total_zero  = total == 32'd0;
    st.sweep_end   = sweep == {AW{1'b1}};
    st.probe_match = match;
    st.probe_last  = probe_i == PW'(spcprof_pkg::PROBE_LIMIT - 1);
    st.best_zero   = best_cnt == 32'd0;
    st.pend        = k != '0;
    st.rep_full    = k == KW'(spcprof_pkg::REPORT_COUNT - 1);
    st.out_last    = last;
  end

  // Memory port selection.
  always_comb begin
    hit_we    = cmd.clr | cmd.take_rd | (cmd.probe_chk & match);
    hit_waddr = slot;
    hit_wdata = hit_inc;
    if (cmd.clr) begin
      hit_waddr = sweep;
      hit_wdata = 32'd0;
    end else if (cmd.take_rd) begin
      hit_waddr = best_idx;
      hit_wdata = 32'd0;
    end
    hit_raddr = cmd.scan_rd ? sweep : slot;
    pc_we     = cmd.probe_chk & match;
    pc_raddr  = cmd.take_rd ? best_idx : slot;
  end

  spcprof_ram #(.WIDTH(32), .DEPTH(spcprof_pkg::TABLE_DEPTH)) u_hit_ram (
    .clk   (clk),
    .we    (hit_we),
    .waddr (hit_waddr),
    .wdata (hit_wdata),
    .raddr (hit_raddr),
    .rdata (hit_rd)
  );

  spcprof_ram #(.WIDTH(32), .DEPTH(spcprof_pkg::TABLE_DEPTH)) u_pc_ram (
    .clk   (clk),
    .we    (pc_we),
    .waddr (slot),
    .wdata (pc_reg),
    .raddr (pc_raddr),
    .rdata (pc_rd)
  );

  // Configuration, tick counter and sample total.
  always_ff @(posedge clk) begin
    if (rst) begin
      en    <= 1'b0;
      mask  <= spcprof_pkg::MASK_RESET;
      tick  <= 16'd0;
      total <= 32'd0;
    end else begin
      if (cfg_we) begin
        case (spcprof_pkg::cfg_index_t'(cfg_index))
          spcprof_pkg::CFG_ENABLE:      en   <= cfg_data[0];
          spcprof_pkg::CFG_SAMPLE_MASK: mask <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.tick) begin
        tick <= tick_next;
        if (st.sample && total != spcprof_pkg::SAT32) begin
          total <= total + 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick) begin
      pc_reg <= pc;
    end
    if (cmd.hash) begin
      slot    <= prod[AW-1:0];
      probe_i <= '0;
    end else if (cmd.probe_chk && !match) begin
      slot    <= slot + AW'(1);
      probe_i <= probe_i + PW'(1);
    end
  end

  // Sweep counter shared by the clearing pass and the hottest-entry search.
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep  <= '0;
      rd_vld <= 1'b0;
      k      <= '0;
    end else begin
      rd_vld <= cmd.scan_rd;
      if (cmd.scan_init) begin
        sweep <= '0;
      end else if (cmd.clr || cmd.scan_rd) begin
        sweep <= sweep + AW'(1);
      end
      if (cmd.rep_init) begin
        k <= '0;
      end else if (cmd.take_load) begin
        k <= k + KW'(1);
      end
    end
  end

  // Running maximum; strict compare keeps the lowest index on ties.
  always_ff @(posedge clk) begin
    rd_idx <= sweep;
    if (cmd.scan_init) begin
      best_cnt <= 32'd0;
      best_idx <= '0;
    end else if (rd_vld && hit_rd > best_cnt) begin
      best_cnt <= hit_rd;
      best_idx <= rd_idx;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.take_load) begin
      rank         <= 5'(k + KW'(1));
      hot_pc       <= pc_rd;
      hit_count    <= best_cnt;
      sample_total <= total;
      last         <= st.rep_full;
    end else if (cmd.mark_last) begin
      last <= 1'b1;
    end
  end

  a_total_mono: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> total >= $past(total))
    else $error("sample total went down");

  a_best_mono: assert property (@(posedge clk) disable iff (rst)
    rd_vld |=> best_cnt >= $past(best_cnt))
    else $error("running maximum went down during a search");

endmodule
`default_nettype wire

### sv/spcprof_ctrl.sv
`default_nettype none
module spcprof_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire spcprof_pkg::sts_t st,
  output spcprof_pkg::cmd_t      cmd
);

  spcprof_pkg::state_t state;
  spcprof_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spcprof_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      spcprof_pkg::S_CLEAR: begin
        if (st.sweep_end) state_next = spcprof_pkg::S_IDLE;
      end
      spcprof_pkg::S_IDLE: begin
        if (in_valid && st.en) begin
          if (st.kind_rep) begin
            if (!st.total_zero) state_next = spcprof_pkg::S_SCAN;
          end else if (st.sample) begin
            state_next = spcprof_pkg::S_HASH;
          end
        end
      end
      spcprof_pkg::S_HASH:     state_next = spcprof_pkg::S_PROBE_RD;
      spcprof_pkg::S_PROBE_RD: state_next = spcprof_pkg::S_PROBE_CHK;
      spcprof_pkg::S_PROBE_CHK: begin
        if (st.probe_match || st.probe_last) begin
          state_next = spcprof_pkg::S_IDLE;
        end else begin
          state_next = spcprof_pkg::S_PROBE_RD;
        end
      end
      spcprof_pkg::S_SCAN: begin
        if (st.sweep_end) state_next = spcprof_pkg::S_SCAN_TAIL;
      end
      spcprof_pkg::S_SCAN_TAIL: state_next = spcprof_pkg::S_DECIDE;
      spcprof_pkg::S_DECIDE: begin
        if (st.pend) begin
          state_next = spcprof_pkg::S_EMIT;
        end else if (st.best_zero) begin
          state_next = spcprof_pkg::S_IDLE;
        end else begin
          state_next = spcprof_pkg::S_TAKE;
        end
      end
      spcprof_pkg::S_TAKE: state_next = spcprof_pkg::S_TAKE_WAIT;
      spcprof_pkg::S_TAKE_WAIT: begin
        if (st.rep_full) begin
          state_next = spcprof_pkg::S_EMIT;
        end else begin
          state_next = spcprof_pkg::S_SCAN;
        end
      end
      spcprof_pkg::S_EMIT: begin
        if (out_ready) begin
          if (st.out_last) begin
            state_next = spcprof_pkg::S_IDLE;
          end else begin
            state_next = spcprof_pkg::S_TAKE;
          end
        end
      end
      default: state_next = spcprof_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state)
      spcprof_pkg::S_CLEAR: cmd.clr = 1'b1;
      spcprof_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && st.en) begin
          if (st.kind_rep) begin
            cmd.rep_init  = !st.total_zero;
            cmd.scan_init = !st.total_zero;
          end else begin
            cmd.tick = 1'b1;
          end
        end
      end
      spcprof_pkg::S_HASH:      cmd.hash = 1'b1;
      spcprof_pkg::S_PROBE_CHK: cmd.probe_chk = 1'b1;
      spcprof_pkg::S_SCAN:      cmd.scan_rd = 1'b1;
      spcprof_pkg::S_DECIDE:    cmd.mark_last = st.pend && st.best_zero;
      spcprof_pkg::S_TAKE:      cmd.take_rd = 1'b1;
      spcprof_pkg::S_TAKE_WAIT: begin
        cmd.take_load = 1'b1;
        cmd.scan_init = !st.rep_full;
      end
      spcprof_pkg::S_EMIT:      out_valid = 1'b1;
      default: ;
    endcase
  end

  a_report_starts: assert property (@(posedge clk) disable iff (rst)
    (state == spcprof_pkg::S_IDLE && in_valid && st.en && st.kind_rep && !st.total_zero)
      |=> state == spcprof_pkg::S_SCAN)
    else $error("accepted report did not start a search");

  a_probe_ends: assert property (@(posedge clk) disable iff (rst)
    (state == spcprof_pkg::S_PROBE_CHK && st.probe_match) |=> in_ready)
    else $error("probe hit did not return to idle");

endmodule
`default_nettype wire
